// ----- sv/alcf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the audio loss concealer with linear fade.
// Used by alcf_scale and audio_loss_conceal_fade; depends on nothing else.

package alcf_pkg;

    // Channel and sample geometry
    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CHANS_W      = $clog2(MAX_CHANNELS + 1);
    localparam int SAMPLE_W     = 32;
    localparam int FADE_W       = 16;

    // Scaling unit: product width and divider pacing
    localparam int PROD_W    = SAMPLE_W + FADE_W;
    localparam int DIV_STEPS = 4;
    localparam int DIV_ITERS = PROD_W / DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_ITERS);

    // Item actions
    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_CONCEAL = 1'b1;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_CHANNELS = 2'd1;
    localparam logic [1:0] REG_FADE     = 2'd2;

    // Register reset values
    localparam logic [CHANS_W-1:0] CHANNELS_RST = CHANS_W'(2);
    localparam logic [FADE_W-1:0]  FADE_RST     = FADE_W'(240);

    // Frame sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } alcf_state_t;

    // Scaling unit phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL,
        PH_DIV,
        PH_FIN
    } alcf_phase_t;

    // Request into the scaling unit
    typedef struct packed {
        logic                       start;
        logic signed [SAMPLE_W-1:0] sample;
        logic [FADE_W-1:0]          num;
        logic [FADE_W-1:0]          divisor;
    } scale_req_t;

    // Answer from the scaling unit
    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] value;
    } scale_rsp_t;

endpackage

// ----- sv/audio_loss_conceal_fade.sv -----
`timescale 1ns / 1ps
// Top level of the multichannel audio loss concealer with linear fade.
// Holds the last sample per channel and sequences alcf_scale over a frame. Uses alcf_pkg.
//
//   port group   direction  words
//   in_*         sink       observe word (one sample) or conceal word (one frame)
//   out_*        source     one faded sample per channel of a concealed frame
//   p*           apb slave  enable_conceal @0x0, channel_count @0x4, fade_length @0x8
//
// An observe word only updates a held sample. A conceal word takes each channel through
// an issue state, a multiply and the divide steps of the shared scaling unit, a finish
// state and the output state, where out_stall can hold the word. The divider works at
// 4 quotient bits a cycle. A silent frame (disabled, or position at or past the fade)
// skips the scaling unit and gives zero samples; with no channels a conceal word gives
// no output words.
// Reset clears held samples and the fade position and loads register defaults.
// in_stall is high for the whole frame; out_stall holds the pending word.

module audio_loss_conceal_fade
    import alcf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input words
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [CH_W-1:0]            channel_in,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       restart_fade,
    // output words
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CH_W-1:0]            channel_out,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_of_frame,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    alcf_state_t state_reg;
    alcf_state_t state_next;

    // configuration registers
    logic                 enable_reg;
    logic [CHANS_W-1:0]   channels_reg;
    logic [FADE_W-1:0]    fade_reg;

    // fade state and held samples
    logic [FADE_W-1:0]    pos_reg;
    logic signed [SAMPLE_W-1:0] held_reg [MAX_CHANNELS];

    // frame datapath
    logic                 active_reg;
    logic [FADE_W-1:0]    num_reg;
    logic [CH_W-1:0]      ch_reg;
    logic                 last_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic                 in_accept;
    logic                 out_accept;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic [CHANS_W-1:0]   chans;
    logic [FADE_W-1:0]    pos_sel;
    logic                 conceal_accept;

    scale_req_t req;
    scale_rsp_t rsp;

    alcf_scale u_scale
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Decode handshakes
    assign in_accept      = in_valid && !in_stall;
    assign out_accept     = out_valid && !out_stall;
    assign conceal_accept = in_accept && (action == ACT_CONCEAL);
    assign cfg_write      = psel && penable && pwrite && pready;
    assign cfg_index      = paddr[3:2];
    assign pready         = 1'b1;

    // Clamp the channel count and pick the starting position
    assign chans   = (channels_reg > CHANS_W'(MAX_CHANNELS)) ? CHANS_W'(MAX_CHANNELS)
                                                              : channels_reg;
    assign pos_sel = restart_fade ? '0 : pos_reg;

    // Read back configuration
    always_comb
    begin
        unique case (cfg_index)
            REG_ENABLE:   prdata = 32'(enable_reg);
            REG_CHANNELS: prdata = 32'(channels_reg);
            REG_FADE:     prdata = 32'(fade_reg);
            default:      prdata = '0;
        endcase
    end

    // Sequence the frame
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (conceal_accept && (chans != '0))
                    state_next = ST_ISSUE;
            ST_ISSUE:
                state_next = active_reg ? ST_WAIT : ST_OUT;
            ST_WAIT:
                if (rsp.done)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_accept)
                    state_next = last_reg ? ST_IDLE : ST_ISSUE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Drive handshakes and the scaling request
    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        out_valid   = (state_reg == ST_OUT);
        req.start   = (state_reg == ST_ISSUE) && active_reg;
        req.sample  = held_reg[ch_reg];
        req.num     = num_reg;
        req.divisor = fade_reg;
    end

    assign channel_out   = ch_reg;
    assign sample_out    = sample_out_reg;
    assign last_of_frame = last_reg;

    // Hold control state, configuration, position and held samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            enable_reg   <= 1'b1;
            channels_reg <= CHANNELS_RST;
            fade_reg     <= FADE_RST;
            pos_reg      <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
                held_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ENABLE:   enable_reg   <= pwdata[0];
                    REG_CHANNELS: channels_reg <= pwdata[CHANS_W-1:0];
                    REG_FADE:     fade_reg     <= pwdata[FADE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // overwrite the held sample of an in-range channel
            if (in_accept && (action == ACT_OBSERVE) && ({1'b0, channel_in} < chans))
                held_reg[channel_in] <= sample_in;

            // advance the position, saturating at the fade length
            if (conceal_accept)
                pos_reg <= (pos_sel < fade_reg) ? pos_sel + FADE_W'(1) : fade_reg;
        end
    end

    // Load frame datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (conceal_accept)
                begin
                    active_reg <= enable_reg && (pos_sel < fade_reg);
                    num_reg    <= fade_reg - pos_sel;
                    ch_reg     <= '0;
                end
            end
            ST_ISSUE:
            begin
                last_reg <= ({1'b0, ch_reg} == (chans - CHANS_W'(1)));
                if (!active_reg)
                    sample_out_reg <= '0;
            end
            ST_WAIT:
            begin
                if (rsp.done)
                    sample_out_reg <= rsp.value;
            end
            ST_OUT:
            begin
                if (out_accept && !last_reg)
                    ch_reg <= ch_reg + CH_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // No new word is taken while a result is pending
    a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while an output word is pending");

    // A delivered word is followed by a new computation, never a repeat
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept |=> !out_valid)
        else $error("output word repeated after delivery");

    // The scaling unit answers only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == ST_WAIT))
        else $error("scaling unit finished outside the wait state");

    // The last word of a frame returns the block to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last_of_frame) |=> !in_stall)
        else $error("block stays busy after the last word of a frame");

endmodule

// ----- sv/alcf_scale.sv -----
`timescale 1ns / 1ps
// Shared scaling unit: sample * num / divisor, truncated toward zero.
// A multiply phase, then a restoring divider at DIV_STEPS bits a cycle. Uses alcf_pkg.

module alcf_scale
    import alcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scale_req_t req,
    output scale_rsp_t rsp
);

    alcf_phase_t phase_reg;
    alcf_phase_t phase_next;

    logic [CNT_W-1:0]    cnt_reg;
    logic [SAMPLE_W-1:0] mag_reg;
    logic [FADE_W-1:0]   num_reg;
    logic [FADE_W-1:0]   div_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   dq_reg;
    logic [FADE_W-1:0]   rem_reg;

    logic [SAMPLE_W-1:0] mag_in;
    logic [PROD_W-1:0]   dq_step;
    logic [FADE_W-1:0]   rem_step;
    logic [SAMPLE_W-1:0] quot;

    // Take the magnitude of the sample; the most negative value maps to 2^31
    assign mag_in = req.sample[SAMPLE_W-1] ? (~req.sample + SAMPLE_W'(1)) : req.sample;

    // Run DIV_STEPS restoring divide steps on remainder and dividend/quotient word
    always_comb
    begin
        logic [FADE_W-1:0] r;
        logic [PROD_W-1:0] d;
        logic [FADE_W:0]   t;
        r = rem_reg;
        d = dq_reg;
        t = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {r, d[PROD_W-1]};
            d = {d[PROD_W-2:0], 1'b0};
            if (t >= {1'b0, div_reg})
            begin
                t    = t - {1'b0, div_reg};
                d[0] = 1'b1;
            end
            r = t[FADE_W-1:0];
        end
        dq_step  = d;
        rem_step = r;
    end

    // Advance the phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (req.start) phase_next = PH_MUL;
            PH_MUL:  phase_next = PH_DIV;
            PH_DIV:  if (cnt_reg == CNT_W'(DIV_ITERS - 1)) phase_next = PH_FIN;
            PH_FIN:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // Drive the answer: quotient sits in the low bits, sign restored here
    assign quot = dq_reg[SAMPLE_W-1:0];

    always_comb
    begin
        rsp.done  = (phase_reg == PH_FIN);
        rsp.value = neg_reg ? (~quot + SAMPLE_W'(1)) : quot;
    end

    // Hold phase and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg == PH_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;
        end
    end

    // Latch operands, multiply, then iterate the divider
    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    mag_reg <= mag_in;
                    neg_reg <= req.sample[SAMPLE_W-1];
                    num_reg <= req.num;
                    div_reg <= req.divisor;
                end
            end
            PH_MUL:
            begin
                dq_reg  <= PROD_W'(mag_reg) * PROD_W'(num_reg);
                rem_reg <= '0;
            end
            PH_DIV:
            begin
                dq_reg  <= dq_step;
                rem_reg <= rem_step;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- dv/audio_loss_conceal_fade_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for audio_loss_conceal_fade: observe and conceal words with random idling.
// Checks every faded output word against a local fade tracker. Depends on alcf_pkg and the RTL.

module audio_loss_conceal_fade_test;
    import alcf_pkg::*;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 600;
    localparam int          SETTLE      = 20;
    localparam logic [1:0]  REG_NONE    = 2'd3;

    // One expected output word of a concealed frame
    typedef struct packed {
        logic [CH_W-1:0]            chan;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       last;
    } faded_word_t;

    logic                       clk;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_stall;
    logic                       action        = ACT_OBSERVE;
    logic [CH_W-1:0]            channel_in    = '0;
    logic signed [SAMPLE_W-1:0] sample_in     = '0;
    logic                       restart_fade  = 1'b0;
    logic                       out_valid;
    logic                       out_stall     = 1'b0;
    logic [CH_W-1:0]            channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_frame;
    logic                       psel          = 1'b0;
    logic                       penable       = 1'b0;
    logic                       pwrite        = 1'b0;
    logic [3:0]                 paddr         = '0;
    logic [31:0]                pwdata        = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // Fade tracker state and register copies
    logic signed [SAMPLE_W-1:0] held_copy [MAX_CHANNELS];
    int                         fpos;
    logic                       cfg_enable;
    logic [4:0]                 cfg_chans;
    logic [FADE_W-1:0]          cfg_fade;
    faded_word_t                faded_due [$];

    int          err_count  = 0;
    int          cycles_run = 0;
    bit          idle_on    = 1'b1;
    int          rx_gap     = 0;
    logic        hold_req   = 1'b0;
    int          hold_left  = 0;

    audio_loss_conceal_fade dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .channel_in    (channel_in),
        .sample_in     (sample_in),
        .restart_fade  (restart_fade),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_out   (channel_out),
        .sample_out    (sample_out),
        .last_of_frame (last_of_frame),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        err_count++;
        $display("mismatch: %s", what);
    endtask

    // Channel count as the block uses it
    function automatic int live_channels();
        return (cfg_chans > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_chans);
    endfunction

    function automatic void fade_reset();
        for (int c = 0; c < MAX_CHANNELS; c++)
            held_copy[c] = '0;
        fpos       = 0;
        cfg_enable = 1'b1;
        cfg_chans  = 5'd2;
        cfg_fade   = FADE_W'(240);
    endfunction

    // Advance the tracker by one accepted word and queue the words it produces
    function automatic void fade_track(input logic act, input logic [CH_W-1:0] ch,
                                       input logic signed [SAMPLE_W-1:0] smp,
                                       input logic restart);
        int          n;
        int          num;
        longint      scaled;
        faded_word_t w;
        n = live_channels();
        if (act == ACT_OBSERVE)
        begin
            if (int'(ch) < n)
                held_copy[ch] = smp;
            return;
        end
        if (restart)
            fpos = 0;
        for (int c = 0; c < n; c++)
        begin
            scaled = 0;
            if (cfg_enable && fpos < int'(cfg_fade))
            begin
                num    = int'(cfg_fade) - fpos;
                scaled = longint'(held_copy[c]) * longint'(num) / longint'(cfg_fade);
            end
            w.chan = CH_W'(c);
            w.smp  = scaled[SAMPLE_W-1:0];
            w.last = (c == n - 1);
            faded_due.push_back(w);
        end
        fpos = (fpos < int'(cfg_fade)) ? fpos + 1 : int'(cfg_fade);
    endfunction

    // Offer one word, hold it until accepted, then update the tracker
    task automatic send_word(input logic act, input logic [CH_W-1:0] ch,
                             input logic [SAMPLE_W-1:0] smp, input logic restart);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        channel_in   <= ch;
        sample_in    <= smp;
        restart_fade <= restart;
        do
            @(negedge clk);
        while (in_stall !== 1'b0);
        @(posedge clk);
        fade_track(act, ch, smp, restart);
    endtask

    // Drop valid and wait until every expected word is out and the block is quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (faded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_read_check(input logic [1:0] idx);
        logic [31:0] want;
        case (idx)
            REG_ENABLE:   want = {31'b0, cfg_enable};
            REG_CHANNELS: want = {27'b0, cfg_chans};
            default:      want = {16'b0, cfg_fade};
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== want)
            flag_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write one register, mirror it, read it back unless it lies past the map
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ENABLE:   cfg_enable = value[0];
            REG_CHANNELS: cfg_chans  = value[4:0];
            REG_FADE:     cfg_fade   = value[FADE_W-1:0];
            default:      ;
        endcase
        @(posedge clk);
        if (idx != REG_NONE)
            reg_read_check(idx);
    endtask

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Check each accepted output word and pace the receiver
    always @(posedge clk)
    begin
        faded_word_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (faded_due.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word ch %0d sample %0d",
                                        channel_out, sample_out));
            end
            else
            begin
                want = faded_due.pop_front();
                if (channel_out !== want.chan)
                    flag_mismatch($sformatf("channel_out %0d, want %0d",
                                            channel_out, want.chan));
                if (sample_out !== want.smp)
                    flag_mismatch($sformatf("ch %0d sample_out %0d, want %0d",
                                            want.chan, sample_out, want.smp));
                if (last_of_frame !== want.last)
                    flag_mismatch($sformatf("ch %0d last_of_frame %b, want %b",
                                            want.chan, last_of_frame, want.last));
            end
            rx_gap = idle_on ? $urandom_range(0, 4) : 0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap--;
        end
        out_stall <= (rx_gap != 0) || (hold_left != 0);
    end

    // Register defaults, then a frame from all-zero held samples
    task automatic test_reset_state();
        reg_read_check(REG_ENABLE);
        reg_read_check(REG_CHANNELS);
        reg_read_check(REG_FADE);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b1);
        drain();
    endtask

    // Every register written and read back; a write past the map changes nothing
    task automatic test_register_map();
        reg_write(REG_ENABLE, 32'd0);
        reg_write(REG_CHANNELS, 32'd5);
        reg_write(REG_FADE, 32'd1000);
        reg_write(REG_NONE, 32'hFFFF_FFFF);
        reg_read_check(REG_ENABLE);
        reg_read_check(REG_CHANNELS);
        reg_read_check(REG_FADE);
        reg_write(REG_ENABLE, 32'd1);
        reg_write(REG_CHANNELS, 32'd2);
        reg_write(REG_FADE, 32'd240);
    endtask

    // Full-scale samples, ignored fields and channels, truncation toward zero
    task automatic test_extremes();
        send_word(ACT_OBSERVE, 4'd0, 32'h7FFF_FFFF, 1'b1);
        send_word(ACT_OBSERVE, 4'd1, 32'h8000_0000, 1'b0);
        send_word(ACT_OBSERVE, 4'd15, 32'd12345, 1'b0);
        send_word(ACT_CONCEAL, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b0);
        send_word(ACT_OBSERVE, 4'd1, 32'hFFFF_FFFF, 1'b0);
        send_word(ACT_CONCEAL, 4'd3, 32'd5, 1'b0);
        drain();
    endtask

    // Fades of one and zero frames, a fade lowered under the position, silence when off
    task automatic test_short_fade();
        reg_write(REG_FADE, 32'd1);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b1);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b0);
        drain();
        reg_write(REG_FADE, 32'd0);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b1);
        drain();
        reg_write(REG_FADE, 32'd240);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b1);
        repeat (3) send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b0);
        drain();
        reg_write(REG_FADE, 32'd2);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b0);
        drain();
        reg_write(REG_FADE, 32'd240);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b0);
        drain();
        reg_write(REG_ENABLE, 32'd0);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b0);
        drain();
        reg_write(REG_ENABLE, 32'd1);
    endtask

    // One channel, no channels, and a count above the maximum
    task automatic test_channel_count();
        reg_write(REG_CHANNELS, 32'd1);
        send_word(ACT_OBSERVE, 4'd0, 32'h0123_4567, 1'b0);
        send_word(ACT_OBSERVE, 4'd1, 32'd99, 1'b0);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b1);
        drain();
        reg_write(REG_CHANNELS, 32'd0);
        send_word(ACT_OBSERVE, 4'd0, 32'd5, 1'b0);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b0);
        drain();
        reg_write(REG_CHANNELS, 32'd31);
        send_word(ACT_OBSERVE, 4'd15, 32'h7FFF_FFFF, 1'b0);
        send_word(ACT_OBSERVE, 4'd7, 32'h8000_0000, 1'b0);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b1);
        drain();
        reg_write(REG_CHANNELS, 32'd16);
        send_word(ACT_CONCEAL, 4'd0, 32'd0, 1'b0);
        drain();
    endtask

    // Packets followed by losses, mixed with stray words, under one setting
    task automatic traffic_phase(input logic en, input logic [4:0] chans,
                                 input logic [15:0] fade, input bit idle, input int n);
        int          sent;
        int          losses;
        int          frames;
        int          n_ch;
        logic [31:0] smp;
        drain();
        reg_write(REG_ENABLE, {31'b0, en});
        reg_write(REG_CHANNELS, {27'b0, chans});
        reg_write(REG_FADE, {16'b0, fade});
        idle_on = idle;
        sent    = 0;
        while (sent < n)
        begin
            n_ch = live_channels();
            if ($urandom_range(0, 9) < 7)
            begin
                frames = $urandom_range(1, 3);
                repeat (frames)
                begin
                    for (int c = 0; c < n_ch; c++)
                    begin
                        case ($urandom_range(0, 7))
                            0:       smp = 32'h7FFF_FFFF;
                            1:       smp = 32'h8000_0000;
                            2:       smp = 32'($urandom_range(0, 600)) - 32'd300;
                            default: smp = $urandom;
                        endcase
                        send_word(ACT_OBSERVE, CH_W'(c), smp, 1'($urandom_range(0, 1)));
                        sent++;
                    end
                end
                losses = $urandom_range(1, 12);
                for (int k = 0; k < losses; k++)
                begin
                    send_word(ACT_CONCEAL, CH_W'($urandom_range(0, 15)), $urandom,
                              (k == 0) ? ($urandom_range(0, 7) != 0) : 1'b0);
                    sent++;
                end
            end
            else
            begin
                send_word(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 15)),
                          $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
        drain();
    endtask

    task automatic test_random_traffic();
        traffic_phase(1'b1, 5'd2, 16'd240, 1'b1, 45);
        traffic_phase(1'b1, 5'd16, 16'd65535, 1'b0, 40);
        traffic_phase(1'b1, 5'd1, 16'd16, 1'b1, 40);
        traffic_phase(1'b0, 5'd8, 16'd100, 1'b1, 30);
        traffic_phase(1'b1, 5'($urandom_range(1, 16)), 16'($urandom_range(16, 300)),
                      1'b1, 50);
        traffic_phase(1'b1, 5'd5, 16'd16, 1'b0, 40);
        traffic_phase(1'b1, 5'd31, 16'd20, 1'b1, 25);
    endtask

    // Hold the receiver off while full frames keep arriving
    task automatic test_backpressure();
        reg_write(REG_CHANNELS, 32'd16);
        reg_write(REG_FADE, 32'd64);
        idle_on  = 1'b0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int c = 0; c < MAX_CHANNELS; c++)
            send_word(ACT_OBSERVE, CH_W'(c), $urandom, 1'b0);
        for (int k = 0; k < 5; k++)
            send_word(ACT_CONCEAL, 4'd0, 32'd0, k == 0);
        drain();
        idle_on = 1'b1;
    endtask

    // Give up on a hung run
    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("audio_loss_conceal_fade_test: errors");
        $finish;
    end

    initial
    begin
        fade_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_register_map();
        test_extremes();
        test_short_fade();
        test_channel_count();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (64) @(posedge clk);
        if (err_count == 0)
            $display("audio_loss_conceal_fade_test: clean");
        else
            $display("audio_loss_conceal_fade_test: errors");
        $finish;
    end

endmodule
